>>> rtl/core/tssd_pkg.sv
`default_nettype none
package tssd_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int MAX_WIDTH   = 32;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_ENC   = 3'd1;
    localparam logic [2:0] ST_BAD_WIDTH = 3'd2;
    localparam logic [2:0] ST_EARLY_END = 3'd3;
    localparam logic [2:0] ST_EXTRA     = 3'd4;
    localparam logic [2:0] ST_MISMATCH  = 3'd5;

    localparam logic [2:0] REG_CODE_TRIVIAL = 3'd0;
    localparam logic [2:0] REG_CODE_VARINT  = 3'd1;
    localparam logic [2:0] REG_CODE_DELTA   = 3'd2;
    localparam logic [2:0] REG_CODE_FIXED   = 3'd3;
    localparam logic [2:0] REG_PAD_BYTES    = 3'd4;

    typedef enum logic [1:0] {
        K_RAW   = 2'd0,
        K_VAR   = 2'd1,
        K_DELTA = 2'd2,
        K_FIXED = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        TK_RES    = 2'd0,   // finished result
        TK_PSTART = 2'd1,   // packed section start: count and width
        TK_PBYTE  = 2'd2    // one packed byte to unpack
    } t_task_kind;

    typedef struct packed {
        t_task_kind  kind;
        logic [31:0] value;
        logic [31:0] rep;
        logic [5:0]  width;
        logic        sec;
        logic        last;
        logic        done;
        logic [2:0]  status;
    } t_task;

    typedef struct packed {
        logic [31:0] value;
        logic [31:0] rep;
        logic        sec;
        logic        last;
        logic        done;
        logic [2:0]  status;
    } t_result;

endpackage
`default_nettype wire

>>> rtl/core/tssd_queue.sv
`default_nettype none
module tssd_queue
    import tssd_pkg::*;
#(
    parameter int P_DEPTH = QUEUE_DEPTH
) (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_push,
    input  t_task i_task,
    input  wire   i_pop,
    output t_task o_task,
    output logic  o_full,
    output logic  o_empty
);
    localparam int PW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CW = $clog2(P_DEPTH + 1);

    t_task          r_mem [P_DEPTH];
    logic [PW-1:0]  r_wr, r_rd;
    logic [CW-1:0]  r_cnt;

    function automatic logic [PW-1:0] f_inc(input logic [PW-1:0] p);
        if (p == PW'(P_DEPTH - 1)) return '0;
        return p + 1'b1;
    endfunction

    assign o_full  = (r_cnt == CW'(P_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_task  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_task;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= f_inc(r_wr);
            if (i_pop)  r_rd <= f_inc(r_rd);
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end
endmodule
`default_nettype wire

>>> rtl/core/tssd_front.sv
`default_nettype none
module tssd_front
    import tssd_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire  [2:0] i_cfg_idx,
    input  wire  [7:0] i_cfg_data,
    input  wire        i_valid,
    input  wire  [7:0] i_byte,
    input  wire        i_end,
    output logic       o_ready,
    input  wire        i_full,
    output logic       o_push,
    output t_task      o_task
);
    typedef enum logic [6:0] {
        PH_ENC   = 7'b0000001,
        PH_WIDTH = 7'b0000010,
        PH_COUNT = 7'b0000100,
        PH_VALS  = 7'b0001000,
        PH_PAD   = 7'b0010000,
        PH_DONE  = 7'b0100000,
        PH_ERR   = 7'b1000000
    } t_phase;

    logic [7:0]  r_code_raw, r_code_var, r_code_delta, r_code_fixed;
    logic [3:0]  r_pad_cfg;

    t_phase      r_phase, n_phase;
    logic        r_sec, n_sec;
    t_kind       r_kind, n_kind;
    logic [31:0] r_items, n_items;
    logic [31:0] r_first, n_first;
    logic [31:0] r_acc, n_acc;
    logic [2:0]  r_shift, n_shift;
    logic [31:0] r_sum, n_sum;
    logic [5:0]  r_width, n_width;
    logic [3:0]  r_pad, n_pad;
    logic [37:0] r_bits, n_bits;
    logic [2:0]  r_err, n_err;

    logic        accept, have_task, sec_done;
    logic [31:0] part, vacc, rpart, racc, dval;
    logic        vdone;
    logic [2:0]  verdict;
    t_task       tk;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_raw   <= 8'd0;
            r_code_var   <= 8'd7;
            r_code_delta <= 8'd8;
            r_code_fixed <= 8'd3;
            r_pad_cfg    <= 4'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CODE_TRIVIAL: r_code_raw   <= i_cfg_data;
                REG_CODE_VARINT:  r_code_var   <= i_cfg_data;
                REG_CODE_DELTA:   r_code_delta <= i_cfg_data;
                REG_CODE_FIXED:   r_code_fixed <= i_cfg_data;
                REG_PAD_BYTES:    r_pad_cfg    <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // LEB128 slice placed at 7 bits per step; fifth byte keeps only 4 bits
    always_comb begin
        case (r_shift)
            3'd0:    part = {25'd0, i_byte[6:0]};
            3'd1:    part = {18'd0, i_byte[6:0], 7'd0};
            3'd2:    part = {11'd0, i_byte[6:0], 14'd0};
            3'd3:    part = {4'd0, i_byte[6:0], 21'd0};
            default: part = {i_byte[3:0], 28'd0};
        endcase
        case (r_shift[1:0])
            2'd0:    rpart = {24'd0, i_byte};
            2'd1:    rpart = {16'd0, i_byte, 8'd0};
            2'd2:    rpart = {8'd0, i_byte, 16'd0};
            default: rpart = {i_byte, 24'd0};
        endcase
    end

    assign vacc  = r_acc | part;
    assign vdone = !i_byte[7] || (r_shift >= 3'd4);
    assign racc  = r_acc | rpart;

    always_comb begin
        n_phase = r_phase; n_sec = r_sec; n_kind = r_kind; n_items = r_items;
        n_first = r_first; n_acc = r_acc; n_shift = r_shift; n_sum = r_sum;
        n_width = r_width; n_pad = r_pad; n_bits = r_bits; n_err = r_err;
        tk        = '0;
        tk.kind   = TK_RES;
        tk.sec    = r_sec;
        have_task = 1'b0;
        sec_done  = 1'b0;
        dval      = vacc;
        verdict   = ST_OK;

        case (r_phase)
            PH_ENC: begin
                n_acc = '0; n_shift = '0;
                n_phase = PH_COUNT;
                if (i_byte == r_code_raw)        n_kind = K_RAW;
                else if (i_byte == r_code_var)   n_kind = K_VAR;
                else if (i_byte == r_code_delta) n_kind = K_DELTA;
                else if (i_byte == r_code_fixed) begin
                    n_kind = K_FIXED; n_phase = PH_WIDTH;
                end else begin
                    n_err = ST_BAD_ENC; n_phase = PH_ERR;
                    tk.status = ST_BAD_ENC; have_task = 1'b1;
                end
            end
            PH_WIDTH: begin
                if (i_byte > 8'(MAX_WIDTH)) begin
                    n_err = ST_BAD_WIDTH; n_phase = PH_ERR;
                    tk.status = ST_BAD_WIDTH; have_task = 1'b1;
                end else begin
                    n_width = i_byte[5:0]; n_phase = PH_COUNT;
                end
            end
            PH_COUNT: begin
                if (!vdone) begin
                    n_acc = vacc; n_shift = r_shift + 3'd1;
                end else begin
                    n_acc = '0; n_shift = '0;
                    if (r_sec && vacc != r_first) begin
                        n_err = ST_MISMATCH; n_phase = PH_ERR;
                        tk.status = ST_MISMATCH; have_task = 1'b1;
                    end else begin
                        if (!r_sec) n_first = vacc;
                        n_items = vacc; n_sum = '0; n_pad = '0;
                        n_bits = 38'(vacc) * 38'(r_width);
                        if (vacc == '0) begin
                            tk.last = 1'b1; have_task = 1'b1; sec_done = 1'b1;
                        end else if (r_kind == K_FIXED && r_width == '0) begin
                            n_items = '0;
                            tk.rep = vacc; tk.last = 1'b1;
                            have_task = 1'b1; sec_done = 1'b1;
                        end else begin
                            n_phase = PH_VALS;
                            if (r_kind == K_FIXED) begin
                                n_pad = r_pad_cfg;
                                tk.kind = TK_PSTART; tk.value = vacc;
                                tk.width = r_width; have_task = 1'b1;
                            end
                        end
                    end
                end
            end
            PH_VALS: begin
                if (r_kind == K_FIXED) begin
                    tk.kind = TK_PBYTE; tk.value = {24'd0, i_byte};
                    have_task = 1'b1;
                    if (r_bits <= 38'd8) begin
                        n_bits = '0;
                        if (r_pad != '0) n_phase = PH_PAD;
                        else sec_done = 1'b1;
                    end else begin
                        n_bits = r_bits - 38'd8;
                    end
                end else if (r_kind == K_RAW) begin
                    if (r_shift >= 3'd3) begin
                        n_acc = '0; n_shift = '0;
                        tk.value = racc; tk.rep = 32'd1;
                        tk.last = (r_items == 32'd1); have_task = 1'b1;
                        n_items = r_items - 32'd1;
                        if (r_items == 32'd1) begin
                            if (r_pad != '0) n_phase = PH_PAD;
                            else sec_done = 1'b1;
                        end
                    end else begin
                        n_acc = racc; n_shift = r_shift + 3'd1;
                    end
                end else begin
                    if (!vdone) begin
                        n_acc = vacc; n_shift = r_shift + 3'd1;
                    end else begin
                        n_acc = '0; n_shift = '0;
                        // delta chain: every value after the first adds to the sum
                        if (r_kind == K_DELTA && r_items != r_first) dval = r_sum + vacc;
                        n_sum = dval;
                        tk.value = dval; tk.rep = 32'd1;
                        tk.last = (r_items == 32'd1); have_task = 1'b1;
                        n_items = r_items - 32'd1;
                        if (r_items == 32'd1) begin
                            if (r_pad != '0) n_phase = PH_PAD;
                            else sec_done = 1'b1;
                        end
                    end
                end
            end
            PH_PAD: begin
                n_pad = r_pad - 4'd1;
                if (r_pad == 4'd1) sec_done = 1'b1;
            end
            PH_DONE: begin
                n_err = ST_EXTRA; n_phase = PH_ERR;
                tk.status = ST_EXTRA; have_task = 1'b1;
            end
            default: ;
        endcase

        if (sec_done) begin
            n_acc = '0; n_shift = '0;
            if (!r_sec) begin
                n_sec = 1'b1; n_phase = PH_ENC;
            end else begin
                n_phase = PH_DONE;
            end
        end

        if (i_end) begin
            if (n_phase == PH_ERR)       verdict = n_err;
            else if (n_phase == PH_DONE) verdict = ST_OK;
            else                         verdict = ST_EARLY_END;
            if (!have_task || tk.kind == TK_PSTART) begin
                // a closing pad byte moves the index on: status result carries it
                tk = '0; tk.kind = TK_RES; tk.sec = n_sec;
            end
            tk.done = 1'b1; tk.status = verdict; have_task = 1'b1;
            n_phase = PH_ENC; n_sec = 1'b0; n_kind = K_RAW; n_items = '0;
            n_first = '0; n_acc = '0; n_shift = '0; n_sum = '0; n_width = '0;
            n_pad = '0; n_bits = '0; n_err = ST_OK;
        end
    end

    assign o_push = accept && have_task;
    assign o_task = tk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_ENC; r_sec <= 1'b0; r_kind <= K_RAW; r_items <= '0;
            r_first <= '0; r_acc <= '0; r_shift <= '0; r_sum <= '0;
            r_width <= '0; r_pad <= '0; r_bits <= '0; r_err <= ST_OK;
        end else if (accept) begin
            r_phase <= n_phase; r_sec <= n_sec; r_kind <= n_kind; r_items <= n_items;
            r_first <= n_first; r_acc <= n_acc; r_shift <= n_shift; r_sum <= n_sum;
            r_width <= n_width; r_pad <= n_pad; r_bits <= n_bits; r_err <= n_err;
        end
    end
endmodule
`default_nettype wire

>>> rtl/core/tssd_back.sv
`default_nettype none
module tssd_back
    import tssd_pkg::*;
(
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  t_task   i_task,
    input  wire     i_empty,
    output logic    o_pop,
    output logic    o_valid,
    input  wire     i_ready,
    output t_result o_res
);
    logic        r_busy, r_end, r_sec;
    logic [2:0]  r_verdict;
    logic [39:0] r_buf, cur_buf;
    logic [5:0]  r_held, cur_held, r_w;
    logic [31:0] r_items;
    logic        r_ovalid;
    t_result     r_o;

    logic        out_free, active, cond, next_cond, emit, cur_end, cur_sec;
    logic [2:0]  cur_verdict;
    logic [32:0] mask;
    t_result     res;

    assign out_free = !r_ovalid || i_ready;
    assign o_pop    = !r_busy && !i_empty && out_free;
    assign active   = r_busy || (o_pop && i_task.kind == TK_PBYTE);

    always_comb begin
        if (r_busy) begin
            cur_buf = r_buf; cur_held = r_held;
            cur_end = r_end; cur_verdict = r_verdict; cur_sec = r_sec;
        end else begin
            cur_buf  = r_buf | (40'(i_task.value[7:0]) << r_held);
            cur_held = r_held + 6'd8;
            cur_end = i_task.done; cur_verdict = i_task.status; cur_sec = i_task.sec;
        end
        mask      = (33'd1 << r_w) - 33'd1;
        cond      = (cur_held >= r_w) && (r_items != '0);
        next_cond = ((cur_held - r_w) >= r_w) && (r_items > 32'd1);
        res  = '0;
        emit = 1'b0;
        if (o_pop && i_task.kind == TK_RES) begin
            emit = 1'b1;
            res.value = i_task.value; res.rep = i_task.rep; res.sec = i_task.sec;
            res.last = i_task.last; res.done = i_task.done; res.status = i_task.status;
        end else if (active && cond && out_free) begin
            emit = 1'b1;
            res.value = cur_buf[31:0] & mask[31:0];
            res.rep   = 32'd1;
            res.sec   = cur_sec;
            res.last  = (r_items == 32'd1);
            if (cur_end && !next_cond) begin
                res.done = 1'b1; res.status = cur_verdict;
            end
        end else if (active && !cond && cur_end) begin
            // byte held no whole value: verdict goes out alone
            emit = 1'b1;
            res.sec = cur_sec; res.done = 1'b1; res.status = cur_verdict;
        end
    end

    assign o_valid = r_ovalid;
    assign o_res   = r_o;

    always_ff @(posedge i_clk) begin
        if (emit) r_o <= res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0; r_busy <= 1'b0; r_end <= 1'b0; r_sec <= 1'b0;
            r_verdict <= ST_OK; r_buf <= '0; r_held <= '0; r_w <= '0; r_items <= '0;
        end else begin
            if (emit) r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;

            if (o_pop && i_task.kind == TK_PSTART) begin
                r_w <= i_task.width; r_items <= i_task.value;
                r_buf <= '0; r_held <= '0;
            end else if (active) begin
                r_end <= cur_end; r_verdict <= cur_verdict; r_sec <= cur_sec;
                if (cond && out_free) begin
                    r_buf   <= cur_buf >> r_w;
                    r_held  <= cur_held - r_w;
                    r_items <= r_items - 32'd1;
                    r_busy  <= next_cond;
                end else if (cond) begin
                    r_buf <= cur_buf; r_held <= cur_held; r_busy <= 1'b1;
                end else begin
                    r_buf <= cur_buf; r_held <= cur_held; r_busy <= 1'b0;
                end
            end
        end
    end
endmodule
`default_nettype wire

>>> rtl/core/trailer_section_stream_decoder.sv
`default_nettype none
// Path: a result is written into the queue, then into the output register.
// Throughput: one input beat per cycle while the queue has room; a packed byte
// that yields k values holds the unpack unit until all are out, the queue between
// parser and unpacker absorbing bursts. Reset: synchronous, active low; clears
// parser, queue and output; registers return to their reset codes.
module trailer_section_stream_decoder
    import tssd_pkg::*;
#(
    parameter int P_QUEUE_DEPTH = QUEUE_DEPTH
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [2:0]  i_cfg_idx,
    input  wire  [7:0]  i_cfg_data,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  wire         i_s_axis_tlast,   // trailer_end
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // [31:0] value, [63:32] repeat_count
    output logic        o_m_axis_tlast,   // last_in_section
    output logic [4:0]  o_m_axis_tuser    // [0] section, [1] trailer_done, [4:2] status
);
    t_task   push_task, pop_task;
    logic    push, pop, full, empty;
    t_result res;

    // front: byte parser, varint/raw assembly, error detection
    tssd_front u_front (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_valid (i_s_axis_tvalid),
        .i_byte  (i_s_axis_tdata),
        .i_end   (i_s_axis_tlast),
        .o_ready (o_s_axis_tready),
        .i_full  (full),
        .o_push  (push),
        .o_task  (push_task)
    );

    tssd_queue #(.P_DEPTH(P_QUEUE_DEPTH)) u_queue (
        .i_clk, .i_rst_n,
        .i_push (push), .i_task (push_task),
        .i_pop  (pop),  .o_task (pop_task),
        .o_full (full), .o_empty (empty)
    );

    // back: bit unpacker plus output register
    tssd_back u_back (
        .i_clk, .i_rst_n,
        .i_task  (pop_task),
        .i_empty (empty),
        .o_pop   (pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_res   (res)
    );

    assign o_m_axis_tdata = {res.rep, res.value};
    assign o_m_axis_tlast = res.last;
    assign o_m_axis_tuser = {res.status, res.done, res.sec};
endmodule
`default_nettype wire

>>> verif/tb_trailer_section_stream_decoder.sv
module tb_trailer_section_stream_decoder;
    import tssd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 12;   // output register sits behind the queue and the unpacker

    // decoder phases, mirrored in the predictor
    localparam int PH_ENC   = 0;
    localparam int PH_WIDTH = 1;
    localparam int PH_COUNT = 2;
    localparam int PH_VALS  = 3;
    localparam int PH_PAD   = 4;
    localparam int PH_DONE  = 5;
    localparam int PH_ERR   = 6;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [7:0]  i_cfg_data = '0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata = '0;   // [7:0] data_byte
    logic        i_s_axis_tlast = 1'b0; // trailer_end
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [63:0] o_m_axis_tdata;        // [31:0] value, [63:32] repeat_count
    logic        o_m_axis_tlast;        // last_in_section
    logic [4:0]  o_m_axis_tuser;        // [0] section, [1] trailer_done, [4:2] status

    trailer_section_stream_decoder dut (.*);

    always #1 i_clk = ~i_clk;

    // stimulus and expectation stores
    t_beat   beat_q[$];
    t_result decoded_q[$];
    int      fail_cnt = 0;
    int      cycle_cnt = 0;
    int      beats_taken = 0;
    bit      reset_done = 1'b0;
    bit      beat_taken = 1'b0;

    // register copies
    logic [7:0] code_of[4];
    logic [3:0] pad_cfg;

    // decoder state copy
    int          ph;
    logic        sec_idx;
    t_kind       kind;
    logic [31:0] items_left, first_cnt, vacc, run_sum;
    logic [2:0]  vsh;
    logic [63:0] bit_buf;
    int          bits_held;
    logic [5:0]  pk_width;
    logic [3:0]  pad_left;
    logic [2:0]  err_code;
    t_result     step_out[$];

    function automatic void clear_decoder();
        ph = PH_ENC; sec_idx = 0; kind = K_RAW; items_left = 0; first_cnt = 0;
        vacc = 0; vsh = 0; run_sum = 0; bit_buf = 0; bits_held = 0; pk_width = 0;
        pad_left = 0; err_code = ST_OK;
    endfunction

    function automatic void put_result(logic [31:0] v, logic [31:0] rep, logic last,
                                       logic [2:0] st);
        t_result r;
        r.value = v; r.rep = rep; r.sec = sec_idx; r.last = last; r.done = 1'b0;
        r.status = st;
        step_out.push_back(r);
    endfunction

    // LEB128 byte; a varint closes on its fifth byte at the latest
    function automatic bit varint_byte(logic [7:0] b, output logic [31:0] res);
        logic [63:0] part;
        part = {57'd0, b[6:0]} << (7 * vsh);
        vacc |= part[31:0];
        if (!b[7] || vsh >= 4) begin
            res = vacc; vacc = 0; vsh = 0;
            return 1'b1;
        end
        vsh++;
        return 1'b0;
    endfunction

    function automatic void raise_err(logic [2:0] code);
        err_code = code; ph = PH_ERR;
        put_result(0, 0, 1'b0, code);
    endfunction

    function automatic void close_section();
        if (sec_idx == 1'b0) begin
            sec_idx = 1'b1; ph = PH_ENC;
        end else begin
            ph = PH_DONE;
        end
        vacc = 0; vsh = 0; bit_buf = 0; bits_held = 0;
    endfunction

    function automatic void emit_value(logic [31:0] v);
        items_left--;
        put_result(v, 1, items_left == 0, ST_OK);
    endfunction

    function automatic void after_value();
        if (items_left == 0) begin
            if (pad_left > 0) ph = PH_PAD;
            else close_section();
        end
    endfunction

    // one accepted input beat -> expected output beats
    function automatic void decode_beat(logic [7:0] b, logic fin);
        logic [31:0] v;
        logic [63:0] mask;
        logic [2:0]  verdict;
        step_out.delete();
        case (ph)
            PH_ENC: begin
                if (b == code_of[0]) kind = K_RAW;
                else if (b == code_of[1]) kind = K_VAR;
                else if (b == code_of[2]) kind = K_DELTA;
                else if (b == code_of[3]) kind = K_FIXED;
                else begin
                    raise_err(ST_BAD_ENC);
                end
                if (ph != PH_ERR) begin
                    vacc = 0; vsh = 0;
                    ph = (kind == K_FIXED) ? PH_WIDTH : PH_COUNT;
                end
            end
            PH_WIDTH: begin
                if (b > MAX_WIDTH) raise_err(ST_BAD_WIDTH);
                else begin
                    pk_width = b[5:0]; ph = PH_COUNT;
                end
            end
            PH_COUNT: begin
                if (varint_byte(b, v)) begin
                    if (sec_idx == 1'b1 && v != first_cnt) raise_err(ST_MISMATCH);
                    else begin
                        if (sec_idx == 1'b0) first_cnt = v;
                        items_left = v; run_sum = 0; bit_buf = 0; bits_held = 0;
                        pad_left = 0;
                        if (v == 0) begin
                            put_result(0, 0, 1'b1, ST_OK); close_section();
                        end else if (kind == K_FIXED && pk_width == 0) begin
                            items_left = 0; put_result(0, v, 1'b1, ST_OK); close_section();
                        end else begin
                            pad_left = (kind == K_FIXED) ? pad_cfg : 4'd0;
                            ph = PH_VALS;
                        end
                    end
                end
            end
            PH_VALS: begin
                if (kind == K_RAW) begin
                    vacc |= {24'd0, b} << (8 * vsh[1:0]);
                    if (vsh >= 3) begin
                        v = vacc; vacc = 0; vsh = 0;
                        emit_value(v); after_value();
                    end else begin
                        vsh++;
                    end
                end else if (kind == K_FIXED) begin
                    mask = (64'd1 << pk_width) - 1;
                    bit_buf |= {56'd0, b} << bits_held;
                    bits_held += 8;
                    while (bits_held >= pk_width && items_left > 0 && step_out.size() < 8) begin
                        emit_value(bit_buf[31:0] & mask[31:0]);
                        bit_buf = bit_buf >> pk_width;
                        bits_held -= pk_width;
                    end
                    after_value();
                end else if (varint_byte(b, v)) begin
                    if (kind == K_DELTA && items_left != first_cnt) v = run_sum + v;
                    run_sum = v;
                    emit_value(v); after_value();
                end
            end
            PH_PAD: begin
                if (pad_left > 0) pad_left--;
                if (pad_left == 0) close_section();
            end
            PH_DONE: raise_err(ST_EXTRA);
            default: ;
        endcase
        if (fin) begin
            verdict = (ph == PH_ERR) ? err_code : (ph == PH_DONE ? ST_OK : ST_EARLY_END);
            if (step_out.size() == 0) put_result(0, 0, 1'b0, verdict);
            step_out[step_out.size() - 1].done = 1'b1;
            step_out[step_out.size() - 1].status = verdict;
            clear_decoder();
        end
        foreach (step_out[i]) decoded_q.push_back(step_out[i]);
    endfunction

    // ---------------------------------------------------------------
    // Scoreboard: prediction on input beats, compare on output beats.
    // Prediction runs first so a same-edge result always finds its entry.
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result exp_r;
        cycle_cnt <= cycle_cnt + 1;
        beat_taken = reset_done && i_s_axis_tvalid && o_s_axis_tready;
        if (beat_taken) begin
            decode_beat(i_s_axis_tdata, i_s_axis_tlast);
            beats_taken++;
        end
        if (reset_done && o_m_axis_tvalid && i_m_axis_tready) begin
            if (decoded_q.size() == 0) begin
                $error("unexpected result beat: value %h rep %h user %b",
                       o_m_axis_tdata[31:0], o_m_axis_tdata[63:32], o_m_axis_tuser);
                fail_cnt++;
            end else begin
                exp_r = decoded_q.pop_front();
                if (o_m_axis_tdata[31:0] !== exp_r.value) begin
                    $error("value: expected %h, got %h", exp_r.value, o_m_axis_tdata[31:0]);
                    fail_cnt++;
                end
                if (o_m_axis_tdata[63:32] !== exp_r.rep) begin
                    $error("repeat_count: expected %h, got %h", exp_r.rep,
                           o_m_axis_tdata[63:32]);
                    fail_cnt++;
                end
                if (o_m_axis_tuser[0] !== exp_r.sec) begin
                    $error("section: expected %b, got %b", exp_r.sec, o_m_axis_tuser[0]);
                    fail_cnt++;
                end
                if (o_m_axis_tlast !== exp_r.last) begin
                    $error("last_in_section: expected %b, got %b", exp_r.last, o_m_axis_tlast);
                    fail_cnt++;
                end
                if (o_m_axis_tuser[1] !== exp_r.done) begin
                    $error("trailer_done: expected %b, got %b", exp_r.done, o_m_axis_tuser[1]);
                    fail_cnt++;
                end
                if (o_m_axis_tuser[4:2] !== exp_r.status) begin
                    $error("status: expected %0d, got %0d", exp_r.status, o_m_axis_tuser[4:2]);
                    fail_cnt++;
                end
            end
        end
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Driver: bursts of beats with random gaps, some bursts gap-free.
    // ---------------------------------------------------------------
    int burst_left = 4;
    int gap_left = 0;

    always @(negedge i_clk) begin
        t_beat nb;
        if (reset_done && !(i_s_axis_tvalid && !beat_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
                i_s_axis_tvalid <= 1'b0;
            end else if (beat_q.size() > 0) begin
                nb = beat_q.pop_front();
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata <= nb.data;
                i_s_axis_tlast <= nb.last;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                end
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Receiver: stall pattern drawn at random from four modes; one long hold-off
    // once traffic is flowing so the internal queue fills and tready drops.
    // ---------------------------------------------------------------
    int  hold_left = 0;
    bit  held_once = 1'b0;
    int  rx_mode = 0;

    always @(negedge i_clk) begin
        if (cycle_cnt % 64 == 0) rx_mode = $urandom_range(0, 3);
        if (!held_once && beats_taken >= 60) begin
            held_once = 1'b1;
            hold_left = 300;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            case (rx_mode)
                0: i_m_axis_tready <= 1'b1;
                1: i_m_axis_tready <= ($urandom_range(0, 1) == 1);
                2: i_m_axis_tready <= ($urandom_range(0, 9) != 0);
                default: i_m_axis_tready <= (cycle_cnt % 3 != 0);
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Trailer builders
    // ---------------------------------------------------------------
    logic [7:0] tr_bytes[$];

    function automatic void add_varint(logic [31:0] v);
        do begin
            tr_bytes.push_back({(v > 127), v[6:0]});
            v = v >> 7;
        end while (v != 0);
    endfunction

    // random value as varint; sometimes an overlong five-byte form
    function automatic void add_rand_varint();
        if ($urandom_range(0, 7) == 0) begin
            repeat (4) tr_bytes.push_back(8'h80 | 8'($urandom));
            tr_bytes.push_back(8'($urandom));
        end else begin
            add_varint($urandom >> $urandom_range(0, 31));
        end
    endfunction

    function automatic logic [31:0] pick_count();
        return ($urandom_range(0, 5) == 0) ? 32'd0 : 32'($urandom_range(1, 6));
    endfunction

    // one well-formed section of the given coding
    function automatic void add_section(t_kind k, logic [31:0] cnt, int w);
        int nbytes;
        tr_bytes.push_back(code_of[k]);
        if (k == K_FIXED) tr_bytes.push_back(8'(w));
        add_varint(cnt);
        case (k)
            K_RAW: repeat (4 * cnt) tr_bytes.push_back(8'($urandom));
            K_VAR, K_DELTA: repeat (cnt) add_rand_varint();
            default: if (w > 0 && cnt > 0) begin
                nbytes = (cnt * w + 7) / 8;
                repeat (nbytes) tr_bytes.push_back(8'($urandom));
                repeat (pad_cfg) tr_bytes.push_back(8'($urandom));
            end
        endcase
    endfunction

    function automatic int pick_width();
        case ($urandom_range(0, 4))
            0: return 0;
            1: return 32;
            2: return 1;
            default: return $urandom_range(1, 31);
        endcase
    endfunction

    function automatic logic [7:0] non_code_byte();
        logic [7:0] b;
        do b = 8'($urandom);
        while (b == code_of[0] || b == code_of[1] || b == code_of[2] || b == code_of[3]);
        return b;
    endfunction

    function automatic void queue_trailer();
        t_beat bt;
        foreach (tr_bytes[i]) begin
            bt.data = tr_bytes[i];
            bt.last = (i == tr_bytes.size() - 1);
            beat_q.push_back(bt);
        end
        tr_bytes.delete();
    endfunction

    function automatic void good_trailer();
        logic [31:0] cnt;
        int w0, w1;
        t_kind k0, k1;
        k0 = t_kind'($urandom_range(0, 3));
        k1 = t_kind'($urandom_range(0, 3));
        w0 = pick_width();
        w1 = pick_width();
        cnt = pick_count();
        // occasionally a huge count on zero-width sections only
        if ($urandom_range(0, 9) == 0) begin
            cnt = $urandom;
            k0 = K_FIXED; k1 = K_FIXED; w0 = 0; w1 = 0;
        end
        add_section(k0, cnt, w0);
        add_section(k1, cnt, w1);
    endfunction

    // random trailer, half of the picks well-formed
    function automatic void rand_trailer();
        int sel;
        int cut;
        sel = $urandom_range(0, 15);
        if (sel < 8) begin
            good_trailer();
        end else if (sel < 10) begin
            good_trailer();
            cut = $urandom_range(1, tr_bytes.size() - 1);
            while (tr_bytes.size() > cut) void'(tr_bytes.pop_back());
        end else if (sel == 10) begin
            good_trailer();
            repeat ($urandom_range(1, 3)) tr_bytes.push_back(8'($urandom));
        end else if (sel == 11) begin
            if ($urandom_range(0, 1)) add_section(t_kind'($urandom_range(0, 3)), pick_count(),
                                                  pick_width());
            tr_bytes.push_back(non_code_byte());
            repeat ($urandom_range(0, 3)) tr_bytes.push_back(8'($urandom));
        end else if (sel == 12) begin
            tr_bytes.push_back(code_of[K_FIXED]);
            tr_bytes.push_back(8'($urandom_range(33, 255)));
            repeat ($urandom_range(0, 2)) tr_bytes.push_back(8'($urandom));
        end else if (sel == 13) begin
            add_section(t_kind'($urandom_range(0, 3)), 32'd3, pick_width());
            tr_bytes.push_back(code_of[K_VAR]);
            add_varint($urandom_range(0, 1) ? 32'd2 : $urandom);
            repeat ($urandom_range(0, 2)) tr_bytes.push_back(8'($urandom));
        end else if (sel == 14) begin
            // huge count, cut off early in the values
            tr_bytes.push_back(code_of[$urandom_range(0, 2)]);
            add_varint($urandom | 32'h8000_0000);
            repeat ($urandom_range(1, 6)) tr_bytes.push_back(8'($urandom));
        end else begin
            repeat ($urandom_range(1, 8)) tr_bytes.push_back(8'($urandom));
        end
        queue_trailer();
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [7:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        if (idx == REG_PAD_BYTES) pad_cfg = val[3:0];
        else code_of[idx] = val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        while (beat_q.size() > 0 || i_s_axis_tvalid || decoded_q.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_codes(logic [7:0] c0, logic [7:0] c1, logic [7:0] c2, logic [7:0] c3,
                             logic [3:0] pad);
        write_reg(REG_CODE_TRIVIAL, c0);
        write_reg(REG_CODE_VARINT, c1);
        write_reg(REG_CODE_DELTA, c2);
        write_reg(REG_CODE_FIXED, c3);
        write_reg(REG_PAD_BYTES, {4'd0, pad});
    endtask

    initial begin
        int n_beats;
        code_of[0] = 8'd0; code_of[1] = 8'd7; code_of[2] = 8'd8; code_of[3] = 8'd3;
        pad_cfg = 4'd0;
        clear_decoder();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        reset_done = 1'b1;

        // directed: reset codes; empty sections, width 0, width 32 packing
        tr_bytes = '{8'd3, 8'd0, 8'd0, 8'd3, 8'd0, 8'd0};
        queue_trailer();
        tr_bytes = '{8'd3, 8'd32, 8'd1, 8'hFF, 8'h00, 8'hFF, 8'h80, 8'd0, 8'd1,
                     8'hFF, 8'hFF, 8'hFF, 8'hFF};
        queue_trailer();
        // delta chain with overlong varint, then extra byte after completion
        tr_bytes = '{8'd8, 8'd2, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'd1,
                     8'd7, 8'd2, 8'd5, 8'd0, 8'hAA};
        queue_trailer();
        wait_idle();

        // extremes: high codes, max padding, width 1 gives eight values per byte
        set_codes(8'd255, 8'd0, 8'd128, 8'd1, 4'd15);
        tr_bytes = '{8'd1, 8'd1, 8'd9, 8'hA5, 8'h01};
        repeat (15) tr_bytes.push_back(8'($urandom));
        tr_bytes.push_back(8'd0); tr_bytes.push_back(8'd9);
        repeat (9) tr_bytes.push_back(8'($urandom));
        queue_trailer();
        tr_bytes = '{8'd77, 8'd0};   // unknown encoding then a stray byte
        queue_trailer();
        tr_bytes = '{8'd1, 8'd33};   // width over 32
        queue_trailer();
        tr_bytes = '{8'd255};        // early end after the encoding byte
        queue_trailer();
        wait_idle();

        // directed beats count toward the total
        n_beats = beats_taken;
        for (int phase_no = 0; phase_no < 6; phase_no++) begin
            case (phase_no)
                0: set_codes(8'd0, 8'd7, 8'd8, 8'd3, 4'd0);
                1: set_codes(8'd255, 8'd254, 8'd0, 8'd1, 4'd15);
                2: set_codes(8'd5, 8'd5, 8'd6, 8'd6, 4'd2);   // shared codes: priority
                default: set_codes(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                                   4'($urandom));
            endcase
            while (beat_q.size() < 70) rand_trailer();
            n_beats += beat_q.size();
            wait_idle();
            if (n_beats >= 370 && phase_no >= 3) break;
        end

        wait_idle();
        if (decoded_q.size() != 0) begin
            $error("%0d expected results never arrived", decoded_q.size());
            fail_cnt++;
        end
        if (fail_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
